// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion with an async
// active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ----- src/chacha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and helper functions of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

	// Default number of rounds per block.
	localparam int unsigned ROUND_COUNT_DEF = 20;

	// Field widths.
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned TDATA_W = 40;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Block constants: "expand 32-byte k" and "expand 16-byte k".
	localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
		32'h3320646e, 32'h61707865};
	localparam logic [3:0][31:0] TAU = {32'h6b206574, 32'h79622d36,
		32'h3120646e, 32'h61707865};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY0      = 3'd0,
		CFG_KEY1      = 3'd1,
		CFG_KEY2      = 3'd2,
		CFG_KEY3      = 3'd3,
		CFG_KEY256    = 3'd4,
		CFG_NONCE     = 3'd5,
		CFG_CTR_START = 3'd6
	} cfg_reg_e;

	// Configuration register contents.
	typedef struct packed {
		logic [63:0] key_part_0;
		logic [63:0] key_part_1;
		logic [63:0] key_part_2;
		logic [63:0] key_part_3;
		logic        key_is_256;
		logic [63:0] nonce_value;
		logic [63:0] counter_start;
	} cfg_t;

	// Request from the item control to the block generator.
	typedef struct packed {
		logic start;
		logic restart;
	} gen_req_t;

	// Status of the block generator.
	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

	// Item control states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_EMIT
	} top_state_t;

	// Block generator states.
	typedef enum logic [1:0] {
		BG_IDLE,
		BG_ROUND,
		BG_FINAL
	} bg_state_t;

	// Rotate left by the amount that belongs to one step of a quarter-round.
	function automatic logic [31:0] step_rotl(input logic [31:0] v, input logic [1:0] step);
		logic [31:0] r;
		unique case (step)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			2'd3: r = {v[24:0], v[31:25]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// ----- src/chacha_qstep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_qstep
// Shared add-xor-rotate unit: one step of four quarter-rounds in parallel.
// ----------------------------------------------------------------------------
module chacha_qstep (
	input  logic [3:0][31:0] x,
	input  logic [3:0][31:0] y,
	input  logic [3:0][31:0] z,
	input  logic [1:0]       step,
	output logic [3:0][31:0] x_new,
	output logic [3:0][31:0] z_new
);
	import chacha_pkg::*;

	// Each lane: x += y; z = rotl(z ^ x, amount of this step).
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			x_new[j] = x[j] + y[j];
			z_new[j] = step_rotl(z[j] ^ x_new[j], step);
		end
	end

endmodule

// ----- src/chacha_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_cfg
// Configuration register file: key, key size, nonce and start counter.
// ----------------------------------------------------------------------------
module chacha_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]    cfg_data,
	output chacha_pkg::cfg_t                     cfg
);
	import chacha_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{key_part_0: '0, key_part_1: '0, key_part_2: '0,
				key_part_3: '0, key_is_256: 1'b1, nonce_value: '0,
				counter_start: '0};
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_KEY0:      cfg_q.key_part_0    <= cfg_data;
				CFG_KEY1:      cfg_q.key_part_1    <= cfg_data;
				CFG_KEY2:      cfg_q.key_part_2    <= cfg_data;
				CFG_KEY3:      cfg_q.key_part_3    <= cfg_data;
				CFG_KEY256:    cfg_q.key_is_256    <= cfg_data[0];
				CFG_NONCE:     cfg_q.nonce_value   <= cfg_data;
				CFG_CTR_START: cfg_q.counter_start <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/chacha_blkgen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_blkgen
// Keystream block generator: loads the input block, runs the rounds through
// the shared quarter-round step unit, then adds the input block back.
// ----------------------------------------------------------------------------
module chacha_blkgen #(
	parameter int unsigned ROUND_COUNT = chacha_pkg::ROUND_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chacha_pkg::cfg_t      cfg,
	input  chacha_pkg::gen_req_t  req,
	output chacha_pkg::gen_stat_t stat,
	input  logic [3:0]            rd_pos,
	output logic [31:0]           rd_word
);
	import chacha_pkg::*;

	localparam int unsigned RW = $clog2(ROUND_COUNT);
	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

	bg_state_t state_q, state_d;
	logic [RW-1:0] round_q;
	logic [1:0]    step_q;
	logic [63:0]   ctr_q;
	logic [31:0]   work_q [16];
	logic [31:0]   ks_q   [16];

	logic [31:0]   init_w [16];
	logic [63:0]   ctr_used;
	logic [63:0]   hi0, hi1;
	logic [3:0]    idx_x [4];
	logic [3:0]    idx_y [4];
	logic [3:0]    idx_z [4];
	logic [3:0][31:0] lane_x, lane_y, lane_z, new_x, new_z;

	// Input block from the configuration and the block counter.
	always_comb begin
		ctr_used = req.restart ? cfg.counter_start : ctr_q;
		hi0 = cfg.key_is_256 ? cfg.key_part_2 : cfg.key_part_0;
		hi1 = cfg.key_is_256 ? cfg.key_part_3 : cfg.key_part_1;
		for (int i = 0; i < 4; i++) begin
			init_w[i] = cfg.key_is_256 ? SIGMA[i] : TAU[i];
		end
		init_w[4]  = cfg.key_part_0[31:0];
		init_w[5]  = cfg.key_part_0[63:32];
		init_w[6]  = cfg.key_part_1[31:0];
		init_w[7]  = cfg.key_part_1[63:32];
		init_w[8]  = hi0[31:0];
		init_w[9]  = hi0[63:32];
		init_w[10] = hi1[31:0];
		init_w[11] = hi1[63:32];
		init_w[12] = ctr_used[31:0];
		init_w[13] = ctr_used[63:32];
		init_w[14] = cfg.nonce_value[31:0];
		init_w[15] = cfg.nonce_value[63:32];
	end

	// Lane routing: column rounds on even round numbers, diagonal on odd.
	// Even steps update a and d, odd steps update c and b.
	always_comb begin
		logic [1:0] jj, bj, cj, dj;
		logic [3:0] ia, ib, ic, id;
		for (int j = 0; j < 4; j++) begin
			jj = 2'(j);
			bj = round_q[0] ? jj + 2'd1 : jj;
			cj = round_q[0] ? jj + 2'd2 : jj;
			dj = round_q[0] ? jj + 2'd3 : jj;
			ia = {2'b00, jj};
			ib = {2'b01, bj};
			ic = {2'b10, cj};
			id = {2'b11, dj};
			idx_x[j] = step_q[0] ? ic : ia;
			idx_y[j] = step_q[0] ? id : ib;
			idx_z[j] = step_q[0] ? ib : id;
			lane_x[j] = work_q[idx_x[j]];
			lane_y[j] = work_q[idx_y[j]];
			lane_z[j] = work_q[idx_z[j]];
		end
	end

	chacha_qstep u_qstep (
		.x     (lane_x),
		.y     (lane_y),
		.z     (lane_z),
		.step  (step_q),
		.x_new (new_x),
		.z_new (new_z)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BG_IDLE:  if (req.start) begin
				state_d = BG_ROUND;
			end
			BG_ROUND: if (step_q == 2'd3 && round_q == LAST_ROUND) begin
				state_d = BG_FINAL;
			end
			BG_FINAL: state_d = BG_IDLE;
			default:  state_d = BG_IDLE;
		endcase
	end

	assign stat.busy = (state_q != BG_IDLE);
	assign stat.done = (state_q == BG_FINAL);

	// Control registers: state, round and step counters, block counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BG_IDLE;
			round_q <= '0;
			step_q  <= '0;
			ctr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BG_IDLE && req.start) begin
				round_q <= '0;
				step_q  <= '0;
				ctr_q   <= ctr_used + 64'd1;
			end else if (state_q == BG_ROUND) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					round_q <= round_q + RW'(1);
				end
			end
		end
	end

	// Working words and keystream block.
	always_ff @(posedge clk) begin
		if (state_q == BG_IDLE && req.start) begin
			for (int i = 0; i < 16; i++) begin
				work_q[i] <= init_w[i];
				ks_q[i]   <= init_w[i];
			end
		end else if (state_q == BG_ROUND) begin
			for (int j = 0; j < 4; j++) begin
				work_q[idx_x[j]] <= new_x[j];
				work_q[idx_z[j]] <= new_z[j];
			end
		end else if (state_q == BG_FINAL) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[i] <= ks_q[i] + work_q[i];
			end
		end
	end

	assign rd_word = ks_q[rd_pos];

endmodule

// ----- src/chacha20_stream_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 (64-bit counter, 64-bit nonce) stream cipher, one word per item.
// ----------------------------------------------------------------------------
// Channel | Signals                              | Direction | Content
// s_*     | s_tvalid s_tready s_tdata s_tlast s_tuser | in   | message word
// m_*     | m_tvalid m_tready m_tdata m_tlast    | out       | cipher word
// cfg_*   | cfg_valid cfg_ready cfg_index cfg_data | in      | register write
//
// A word at a nonzero block position goes from ST_IDLE to ST_EMIT, and its
// result is loaded into the output register as soon as that register is free.
// A word at position zero (or with restart) first waits in ST_WAIT while the
// block generator runs all rounds through the shared quarter-round step unit
// and then the feed-forward step, and passes through ST_EMIT the same way.
// One item is in work at a time; s_tready is low meanwhile, and the next
// item can be taken while a result still waits in the output register.
// Reset clears control state and sets a 256-bit key; no clearing pass.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int unsigned ROUND_COUNT = chacha_pkg::ROUND_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] data_in, [34:32] byte_count, [39:35] zero
	input  logic [chacha_pkg::TDATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	// [0] restart
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] data_out, [34:32] out_byte_count, [39:35] zero
	output logic [chacha_pkg::TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data
);
	import chacha_pkg::*;

	top_state_t state_q, state_d;
	cfg_t       cfg;
	gen_req_t   req;
	gen_stat_t  stat;

	logic [3:0]         pos_q;
	logic [3:0]         eff_pos;
	logic [WORD_W-1:0]  data_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;
	logic [WORD_W-1:0]  ks_word;
	logic [WORD_W-1:0]  mask;
	logic [WORD_W-1:0]  dout_q;
	logic [COUNT_W-1:0] ocount_q;
	logic               olast_q;
	logic               mvalid_q;
	logic               accept;
	logic               out_free;
	logic               load_out;

	chacha_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	chacha_blkgen #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_blkgen (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req     (req),
		.stat    (stat),
		.rd_pos  (pos_q),
		.rd_word (ks_word)
	);

	// Handshake and block request. A restart forces position zero.
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign eff_pos     = s_tuser ? 4'd0 : pos_q;
	assign req.start   = accept && (eff_pos == 4'd0);
	assign req.restart = accept && s_tuser;
	assign out_free    = !mvalid_q || m_tready;
	assign load_out    = (state_q == ST_EMIT) && out_free;

	// Item control next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				state_d = (eff_pos == 4'd0) ? ST_WAIT : ST_EMIT;
			end
			ST_WAIT: if (stat.done) begin
				state_d = ST_EMIT;
			end
			ST_EMIT: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Byte i is kept when the byte count exceeds i.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mask[8*i +: 8] = {8{count_q > COUNT_W'(i)}};
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pos_q <= eff_pos;
			end else if (load_out) begin
				pos_q <= last_q ? 4'd0 : pos_q + 4'd1;
			end
			if (load_out) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q  <= s_tdata[WORD_W-1:0];
			count_q <= s_tdata[WORD_W +: COUNT_W];
			last_q  <= s_tlast;
		end
		if (load_out) begin
			dout_q   <= (data_q ^ ks_word) & mask;
			ocount_q <= count_q;
			olast_q  <= last_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {(TDATA_W - WORD_W - COUNT_W)'(0), ocount_q, dout_q};
	assign m_tlast  = olast_q;

endmodule

// ----- src/chacha_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// chacha_checker
// Port-level checks of the stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module chacha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds its payload.
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// The block is busy right after it takes an item.
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A one-byte result has zero in its upper bytes.
	`CHK_SAME(a_one_byte_masked, clk, arst_n, m_tvalid && m_tdata[34:32] == 3'd1, m_tdata[31:8] == 24'd0)

	// A result with no valid byte is all zero.
	`CHK_SAME(a_zero_bytes_masked, clk, arst_n, m_tvalid && m_tdata[34:32] == 3'd0, m_tdata[31:0] == 32'd0)

endmodule

bind chacha20_stream_cipher chacha_checker u_chacha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
